### rtl/wbps_pkg.sv
package wbps_pkg;

    localparam int MaxPattern = 16;
    localparam int LenW       = $clog2(MaxPattern + 1);
    localparam int PosW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
    localparam int AddrW      = 64;
    localparam int CfgDataW   = 64;
    localparam int CfgIdxW    = 3;
    localparam int CareW      = 16;

    typedef logic [7:0]          t_byte;
    typedef logic [AddrW-1:0]    t_addr;
    typedef logic [LenW-1:0]     t_len;
    typedef logic [CfgDataW-1:0] t_cfg_data;

    typedef enum logic [CfgIdxW-1:0] {
        CfgPatternLow  = 3'd0,
        CfgPatternHigh = 3'd1,
        CfgCareMask    = 3'd2,
        CfgPatternLen  = 3'd3,
        CfgFindAll     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic advance;
        logic flush;
        logic in_use;
        logic match;
    } t_cell_ctrl;

    function automatic t_len clamp_len(input logic [4:0] raw);
        t_len len;
        if (raw == 5'd0) begin
            len = t_len'(1);
        end else if ({27'd0, raw} > MaxPattern) begin
            len = t_len'(MaxPattern);
        end else begin
            len = t_len'(raw);
        end
        return len;
    endfunction

endpackage

### rtl/wbps_if.sv
interface wbps_in_if;
    import wbps_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    t_addr byte_address;
    logic  region_start;
    logic  scan_start;

    modport source (output valid, output data_byte, output byte_address,
                    output region_start, output scan_start, input ready);
    modport sink   (input valid, input data_byte, input byte_address,
                    input region_start, input scan_start, output ready);
endinterface

interface wbps_out_if;
    import wbps_pkg::*;

    logic  valid;
    logic  ready;
    t_addr match_address;

    modport source (output valid, output match_address, input ready);
    modport sink   (input valid, input match_address, output ready);
endinterface

### rtl/wbps_cell.sv
module wbps_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wbps_pkg::t_cell_ctrl   i_ctrl,
    input  logic                   i_prev,
    input  logic                   i_care,
    input  wbps_pkg::t_byte        i_pattern,
    input  wbps_pkg::t_byte        i_data,
    output logic                   o_hit,
    output logic                   o_flag
);
    logic r_flag;
    logic n_flag;
    logic w_cand;

    assign w_cand = i_prev & ~i_ctrl.flush & i_ctrl.in_use;
    assign o_hit  = w_cand & (~i_care | (i_pattern == i_data));
    assign n_flag = o_hit & ~i_ctrl.match;
    assign o_flag = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_flag <= n_flag;
        end
    end
endmodule

### rtl/wildcard_byte_pattern_scanner_top.sv
// Masked byte signature scanner. Takes one memory byte per cycle and compares it against a
// pattern of up to 16 bytes, where cleared care-mask bits are wildcards. A row of cells, one
// per pattern position, holds the partial-match flags; each accepted byte moves them one cell
// along. A match must lie inside one region, clears all partial matches (matches never
// overlap) and returns the address of its first byte in the cycle after the last byte's
// transaction. With find_all clear only the first match after a scan start is reported.
// Throughput is one byte per cycle; the result sits in an output register, so input stays
// ready while that register is empty or being taken. Write configuration only while idle.
module wildcard_byte_pattern_scanner_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  wbps_pkg::t_cfg_idx    i_cfg_index,
    input  wbps_pkg::t_cfg_data   i_cfg_wdata,
    wbps_in_if.sink               i_in,
    wbps_out_if.source            o_out
);
    import wbps_pkg::*;

    logic [63:0]            r_pat_lo;
    logic [63:0]            r_pat_hi;
    logic [CareW-1:0]       r_care;
    t_len                   r_len;
    logic                   r_find_all;
    logic                   r_taken;
    logic                   n_taken;
    logic                   r_out_valid;
    t_addr                  r_out_addr;
    t_addr                  n_out_addr;

    logic [127:0]           w_pattern;
    logic [MaxPattern-1:0]  w_hit;
    logic [MaxPattern-1:0]  w_prev;
    logic [MaxPattern-1:0]  w_flag;
    logic [PosW-1:0]        w_last;
    logic                   w_accept;
    logic                   w_flush;
    logic                   w_match;
    logic                   w_taken_eff;
    logic                   w_report;
    t_cell_ctrl             w_ctrl [MaxPattern];

    assign w_pattern   = {r_pat_hi, r_pat_lo};
    assign i_in.ready  = ~r_out_valid | o_out.ready;
    assign w_accept    = i_in.valid & i_in.ready;
    assign w_flush     = i_in.region_start | i_in.scan_start;
    assign w_last      = PosW'(r_len - t_len'(1));
    assign w_match     = w_hit[w_last];
    assign w_taken_eff = r_taken & ~i_in.scan_start;
    assign w_report    = w_match & (r_find_all | ~w_taken_eff);
    assign n_taken     = w_match | w_taken_eff;
    assign n_out_addr  = i_in.byte_address - AddrW'(w_last);
    assign w_prev      = {w_flag[MaxPattern-2:0], 1'b1};

    assign o_out.valid         = r_out_valid;
    assign o_out.match_address = r_out_addr;

    genvar k;
    generate
        for (k = 0; k < MaxPattern; k++) begin : g_cell
            assign w_ctrl[k].advance = w_accept;
            assign w_ctrl[k].flush   = (k == 0) ? 1'b0 : w_flush;
            assign w_ctrl[k].in_use  = t_len'(k) < r_len;
            assign w_ctrl[k].match   = w_match;

            wbps_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl[k]),
                .i_prev    (w_prev[k]),
                .i_care    (r_care[k]),
                .i_pattern (w_pattern[8*k +: 8]),
                .i_data    (i_in.data_byte),
                .o_hit     (w_hit[k]),
                .o_flag    (w_flag[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo   <= '0;
            r_pat_hi   <= '0;
            r_care     <= '0;
            r_len      <= t_len'(1);
            r_find_all <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgPatternLow:  r_pat_lo   <= i_cfg_wdata;
                CfgPatternHigh: r_pat_hi   <= i_cfg_wdata;
                CfgCareMask:    r_care     <= i_cfg_wdata[CareW-1:0];
                CfgPatternLen:  r_len      <= clamp_len(i_cfg_wdata[4:0]);
                CfgFindAll:     r_find_all <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_taken     <= n_taken;
            r_out_valid <= w_report;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_report) begin
            r_out_addr <= n_out_addr;
        end
    end
endmodule

### rtl/wbps_checker.sv
module wbps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input wbps_pkg::t_addr     i_out_addr
);
    import wbps_pkg::*;

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in_valid & i_in_ready;
    assign w_out_acc = i_out_valid & i_out_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_addr)))
        else $error("result dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc))
        else $error("result without an input transaction");

    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !w_in_acc) |=> !i_out_valid)
        else $error("result repeated");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_addr  (o_out.match_address)
);

### verif/wildcard_byte_pattern_scanner_top_tb.sv
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_top_tb;
    import wbps_pkg::*;

    localparam int CycleLimit  = 500000;
    localparam int RandomItems = 1450;
    localparam int HoldCycles  = 300;

    typedef struct packed {
        logic      is_write;
        t_cfg_idx  idx;
        t_cfg_data value;
        t_byte     data;
        t_addr     addr;
        logic      region;
        logic      scan;
        logic      typed;
        logic      hit;
        t_addr     where;
    } t_step_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_wdata;

    wbps_in_if  in_ch ();
    wbps_out_if out_ch ();

    wildcard_byte_pattern_scanner_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // scanner state and registers as the predictor sees them
    t_cfg_data   pat_lo         = '0;
    t_cfg_data   pat_hi         = '0;
    logic [15:0] care_bits      = '0;
    logic [4:0]  len_raw        = 5'd1;
    logic        find_all_bit   = 1'b1;
    logic [15:0] match_flags    = '0;
    logic        first_hit_seen = 1'b0;

    t_addr pending_matches[$];
    t_addr oldest_match;
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    int    hold_request   = 0;
    bit    recv_fast      = 1'b0;
    bit    send_fast      = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic int active_len();
        if (len_raw == 5'd0) return 1;
        if (int'(len_raw) > MaxPattern) return MaxPattern;
        return int'(len_raw);
    endfunction

    function automatic t_byte pattern_at(input int pos);
        logic [127:0] both;
        both = {pat_hi, pat_lo};
        return both[8*pos +: 8];
    endfunction

    function automatic int pick_gap();
        return send_fast ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic t_step_row reg_row(input t_cfg_idx idx, input t_cfg_data value);
        t_step_row r;
        r          = '0;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = value;
        return r;
    endfunction

    function automatic t_step_row item_row(input t_byte data, input t_addr addr,
                                           input bit region, input bit scan,
                                           input bit typed, input bit hit,
                                           input t_addr where);
        t_step_row r;
        r        = '0;
        r.data   = data;
        r.addr   = addr;
        r.region = region;
        r.scan   = scan;
        r.typed  = typed;
        r.hit    = hit;
        r.where  = where;
        return r;
    endfunction

    task automatic scan_byte(input t_byte data, input t_addr addr, input bit region,
                             input bit scan, output bit hit, output t_addr where);
        int          len;
        logic [16:0] cand;
        logic [15:0] nxt;
        len   = active_len();
        hit   = 1'b0;
        where = '0;
        nxt   = '0;
        if (scan) begin
            match_flags    = '0;
            first_hit_seen = 1'b0;
        end
        if (region) begin
            match_flags = '0;
        end
        cand = {match_flags, 1'b1} & ((17'd1 << len) - 17'd1);
        for (int k = 0; k < len; k++) begin
            if (cand[k] && (!care_bits[k] || pattern_at(k) == data)) begin
                nxt[k] = 1'b1;
            end
        end
        if (nxt[len-1]) begin
            hit            = find_all_bit || !first_hit_seen;
            where          = addr - t_addr'(len - 1);
            match_flags    = '0;
            first_hit_seen = 1'b1;
        end else begin
            match_flags = nxt;
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgPatternLow:  pat_lo       = value;
            CfgPatternHigh: pat_hi       = value;
            CfgCareMask:    care_bits    = value[15:0];
            CfgPatternLen:  len_raw      = value[4:0];
            CfgFindAll:     find_all_bit = value[0];
            default: ;
        endcase
    endtask

    task automatic drive_item(input t_byte data, input t_addr addr, input bit region,
                              input bit scan, input int gap, input bit typed,
                              input bit typed_hit, input t_addr typed_where);
        bit    hit;
        t_addr where;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= data;
        in_ch.byte_address <= addr;
        in_ch.region_start <= region;
        in_ch.scan_start   <= scan;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        scan_byte(data, addr, region, scan, hit, where);
        if (typed) begin
            hit   = typed_hit;
            where = typed_where;
        end
        if (hit) pending_matches = {pending_matches, where};
    endtask

    // drop valid, drain all matches, then allow the last byte to clear the pipe
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result receiver with per-transaction stalls and an occasional long hold-off
    initial begin
        int hold_left;
        int stall_left;
        hold_left    = 0;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready) begin
                stall_left = recv_fast ? 0 : int'($urandom_range(0, 17));
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end else if (out_ch.valid === 1'b1 && out_ch.ready) begin
            if (pending_matches.size() == 0) begin
                $error("match_address: expected none, got %h", out_ch.match_address);
                mismatch_count++;
            end else begin
                oldest_match = pending_matches.pop_front();
                if (out_ch.match_address !== oldest_match) begin
                    $error("match_address: expected %h, got %h",
                           oldest_match, out_ch.match_address);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_step_row   opening_steps[$];
        t_byte       region_bytes[$];
        t_addr       base;
        t_byte       b;
        int          rlen;
        int          eff;
        int          pick;
        int          bad_pos;
        int          len_pick;
        int          phase_no;
        int          phase_goal;
        int          random_items;
        bit          new_scan;
        bit          first_region;
        logic [15:0] care_pick;
        t_cfg_data   lo_pick;
        t_cfg_data   hi_pick;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CfgPatternLow;
        i_cfg_wdata        = '0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.byte_address = '0;
        in_ch.region_start = 1'b0;
        in_ch.scan_start   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: single wildcard position, every byte matches at its own address
        opening_steps = {opening_steps, item_row(8'h00, '0, 1, 1, 1, 1, '0)};
        opening_steps = {opening_steps, item_row(8'hFF, '1, 1, 0, 1, 1, '1)};
        // zero length behaves as one
        opening_steps = {opening_steps, reg_row(CfgPatternLen, 64'd0)};
        opening_steps = {opening_steps, reg_row(CfgCareMask, 64'd1)};
        opening_steps = {opening_steps, reg_row(CfgPatternLow, 64'hA5)};
        opening_steps = {opening_steps, item_row(8'hA5, 64'h1000, 1, 0, 1, 1, 64'h1000)};
        opening_steps = {opening_steps, item_row(8'h5A, 64'h1001, 0, 0, 1, 0, '0)};
        // oversized length clamps to sixteen; match straddles the address wrap
        opening_steps = {opening_steps, reg_row(CfgPatternLow, 64'h0706_0504_0302_0100)};
        opening_steps = {opening_steps, reg_row(CfgPatternHigh, 64'h0F0E_0D0C_0B0A_0908)};
        opening_steps = {opening_steps, reg_row(CfgCareMask, 64'hFFFF)};
        opening_steps = {opening_steps, reg_row(CfgPatternLen, 64'd31)};
        for (int k = 0; k < 16; k++) begin
            opening_steps = {opening_steps,
                             item_row(t_byte'(k), 64'hFFFF_FFFF_FFFF_FFF8 + t_addr'(k),
                                      k == 0, 0, k == 15, k == 15,
                                      64'hFFFF_FFFF_FFFF_FFF8)};
        end
        // first-only mode, switched on after a match in the same scan
        opening_steps = {opening_steps, reg_row(CfgPatternLen, 64'd1)};
        opening_steps = {opening_steps, reg_row(CfgCareMask, 64'd0)};
        opening_steps = {opening_steps, item_row(8'h3C, 64'h20, 1, 1, 1, 1, 64'h20)};
        opening_steps = {opening_steps, reg_row(CfgFindAll, 64'd0)};
        opening_steps = {opening_steps, item_row(8'hC3, 64'h21, 0, 0, 1, 0, '0)};
        opening_steps = {opening_steps, item_row(8'h81, 64'h22, 1, 1, 1, 1, 64'h22)};
        opening_steps = {opening_steps, item_row(8'h7E, 64'h23, 0, 0, 1, 0, '0)};
        opening_steps = {opening_steps, reg_row(CfgFindAll, 64'd1)};

        foreach (opening_steps[n]) begin
            if (opening_steps[n].is_write) begin
                settle();
                write_reg(opening_steps[n].idx, opening_steps[n].value);
            end else begin
                drive_item(opening_steps[n].data, opening_steps[n].addr,
                           opening_steps[n].region, opening_steps[n].scan, pick_gap(),
                           opening_steps[n].typed, opening_steps[n].hit,
                           opening_steps[n].where);
            end
        end

        phase_no     = 0;
        random_items = 0;
        while (random_items < RandomItems) begin
            settle();
            if (phase_no == 2) begin
                // output held off while bytes keep coming: every byte matches
                write_reg(CfgPatternLen, 64'd1);
                write_reg(CfgCareMask, 64'd0);
                write_reg(CfgFindAll, 64'd1);
                send_fast    = 1'b1;
                hold_request = HoldCycles;
                base         = {$urandom, $urandom};
                for (int n = 0; n < 40; n++) begin
                    drive_item(t_byte'($urandom), base + t_addr'(n), n == 0, n == 0, 0,
                               0, 0, '0);
                end
                random_items += 40;
            end else begin
                case ($urandom_range(0, 7))
                    0: len_pick = 0;
                    1: len_pick = 1;
                    2: len_pick = 16;
                    3: len_pick = 31;
                    4: len_pick = $urandom_range(17, 31);
                    5: len_pick = $urandom_range(7, 15);
                    default: len_pick = $urandom_range(1, 6);
                endcase
                case ($urandom_range(0, 3))
                    0: care_pick = '0;
                    1: care_pick = '1;
                    default: care_pick = 16'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0: lo_pick = '0;
                    1: lo_pick = '1;
                    default: lo_pick = {$urandom, $urandom};
                endcase
                case ($urandom_range(0, 5))
                    0: hi_pick = '0;
                    1: hi_pick = '1;
                    default: hi_pick = {$urandom, $urandom};
                endcase
                write_reg(CfgPatternLow, lo_pick);
                write_reg(CfgPatternHigh, hi_pick);
                write_reg(CfgCareMask, t_cfg_data'(care_pick));
                write_reg(CfgPatternLen, t_cfg_data'(len_pick));
                write_reg(CfgFindAll, t_cfg_data'($urandom_range(0, 3) != 0));
                send_fast    = ($urandom_range(0, 3) == 0);
                recv_fast    = ($urandom_range(0, 3) == 0);
                phase_goal   = random_items + $urandom_range(60, 160);
                first_region = 1'b1;
                eff          = active_len();
                while (random_items < phase_goal && random_items < RandomItems) begin
                    case ($urandom_range(0, 7))
                        0: base = '1 - t_addr'($urandom_range(0, 20));
                        1: base = t_addr'($urandom_range(0, 20));
                        default: base = {$urandom, $urandom};
                    endcase
                    rlen = $urandom_range(1, 2 * eff + 24);
                    region_bytes.delete();
                    // mostly planted signatures, some with one byte spoilt, plus noise
                    while (region_bytes.size() < rlen) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6) begin
                            bad_pos = (pick == 5) ? int'($urandom_range(0, eff - 1)) : -1;
                            for (int k = 0; k < eff; k++) begin
                                b = care_bits[k] ? pattern_at(k) : t_byte'($urandom);
                                if (k == bad_pos) b = b ^ (8'h01 << $urandom_range(0, 7));
                                region_bytes = {region_bytes, b};
                            end
                        end else if (pick < 8) begin
                            region_bytes = {region_bytes, t_byte'($urandom)};
                        end else begin
                            region_bytes = {region_bytes,
                                            pattern_at($urandom_range(0, eff - 1))};
                        end
                    end
                    new_scan = first_region || ($urandom_range(0, 3) == 0);
                    for (int n = 0; n < rlen; n++) begin
                        drive_item(region_bytes[n], base + t_addr'(n),
                                   (n == 0 && $urandom_range(0, 9) != 0)
                                       || $urandom_range(0, 49) == 0,
                                   (n == 0 && new_scan) || $urandom_range(0, 99) == 0,
                                   pick_gap(), 0, 0, '0);
                    end
                    random_items += rlen;
                    first_region = 1'b0;
                end
            end
            phase_no++;
        end

        settle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
